>>> rtl/core/jsv_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// jsv_pkg
// Shared types, byte codes and the scan state record of the JSON string
// validator.
// ============================================================================
package jsv_pkg;

   // Width of the saturating length counter
   localparam int LENGTH_BITS = 16;
   // Width of the raw_length field on the result port
   localparam int RSP_LENGTH_BITS = 16;

   typedef logic [LENGTH_BITS-1:0]     len_type;
   typedef logic [RSP_LENGTH_BITS-1:0] rsp_len_type;

   // Characters of interest
   localparam logic [7:0] BYTE_QUOTE     = 8'h22;
   localparam logic [7:0] BYTE_BSLASH    = 8'h5C;
   localparam logic [7:0] BYTE_SLASH     = 8'h2F;
   localparam logic [7:0] BYTE_LOWER_B   = 8'h62;
   localparam logic [7:0] BYTE_LOWER_F   = 8'h66;
   localparam logic [7:0] BYTE_LOWER_N   = 8'h6E;
   localparam logic [7:0] BYTE_LOWER_R   = 8'h72;
   localparam logic [7:0] BYTE_LOWER_T   = 8'h74;
   localparam logic [7:0] BYTE_LOWER_U   = 8'h75;
   localparam logic [7:0] BYTE_SPACE     = 8'h20;
   localparam logic [7:0] BYTE_DIGIT_0   = 8'h30;
   localparam logic [7:0] BYTE_DIGIT_9   = 8'h39;
   localparam logic [7:0] BYTE_UPPER_A   = 8'h41;
   localparam logic [7:0] BYTE_UPPER_F   = 8'h46;
   localparam logic [7:0] BYTE_LOWER_A   = 8'h61;

   // UTF-8 lead and continuation bounds
   localparam logic [7:0] UTF8_ASCII_TOP = 8'h80;
   localparam logic [7:0] UTF8_LEAD2_LO  = 8'hC2;
   localparam logic [7:0] UTF8_LEAD2_HI  = 8'hDF;
   localparam logic [7:0] UTF8_LEAD_E0   = 8'hE0;
   localparam logic [7:0] UTF8_LEAD_ED   = 8'hED;
   localparam logic [7:0] UTF8_LEAD3_HI  = 8'hEF;
   localparam logic [7:0] UTF8_LEAD_F0   = 8'hF0;
   localparam logic [7:0] UTF8_LEAD4_HI  = 8'hF3;
   localparam logic [7:0] UTF8_LEAD_F4   = 8'hF4;
   localparam logic [7:0] UTF8_CONT_LO   = 8'h80;
   localparam logic [7:0] UTF8_CONT_HI   = 8'hBF;
   localparam logic [7:0] UTF8_LO_AFTER_E0 = 8'hA0;
   localparam logic [7:0] UTF8_LO_AFTER_F0 = 8'h90;
   localparam logic [7:0] UTF8_HI_AFTER_ED = 8'h9F;
   localparam logic [7:0] UTF8_HI_AFTER_F4 = 8'h8F;

   // UTF-16 surrogate bounds
   localparam logic [15:0] SURR_HIGH_LO = 16'hD800;
   localparam logic [15:0] SURR_LOW_LO  = 16'hDC00;
   localparam logic [15:0] SURR_LOW_HI  = 16'hDFFF;

   localparam logic [2:0] HEX_DIGITS = 3'd4;

   typedef enum logic [2:0] {
      MODE_IDLE = 3'd0,
      MODE_BODY = 3'd1,
      MODE_ESC  = 3'd2,
      MODE_HEX  = 3'd3,
      MODE_UTF8 = 3'd4
   } mode_type;

   // Bound on the first continuation byte
   typedef enum logic [1:0] {
      RANGE_FULL       = 2'd0,
      RANGE_RAISED_LO  = 2'd1,
      RANGE_LOWERED_HI = 2'd2
   } range_type;

   typedef enum logic [1:0] {
      STATUS_SCAN   = 2'd0,
      STATUS_CLOSED = 2'd1,
      STATUS_ERROR  = 2'd2,
      STATUS_IDLE   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ERR_NONE         = 3'd0,
      ERR_CONTROL      = 3'd1,
      ERR_ESCAPE       = 3'd2,
      ERR_HEX          = 3'd3,
      ERR_SURROGATE    = 3'd4,
      ERR_UTF8         = 3'd5,
      ERR_UNTERMINATED = 3'd6
   } err_type;

   typedef struct packed {
      mode_type    mode;
      logic [2:0]  hex_left;
      logic [15:0] escape_value;
      logic [1:0]  cont_left;
      range_type   cont_range;
      logic        surr_pending;
      logic        escape_flag;
      len_type     length;
   } scan_state_type;

   localparam scan_state_type RESET_STATE = '{
      mode:         MODE_IDLE,
      hex_left:     3'd0,
      escape_value: 16'd0,
      cont_left:    2'd0,
      cont_range:   RANGE_FULL,
      surr_pending: 1'b0,
      escape_flag:  1'b0,
      length:       '0
   };

   // Verdict of one scan step
   typedef struct packed {
      status_type status;
      err_type    kind;
   } verdict_type;

   // One result word
   typedef struct packed {
      status_type  status;
      err_type     kind;
      logic        escape_seen;
      rsp_len_type raw_length;
   } rsp_word_type;

endpackage

>>> rtl/core/jsv_step.sv
`timescale 1ns / 1ps
// ============================================================================
// jsv_step
// Next-state and verdict logic for one byte of a quoted JSON string.
// ============================================================================
module jsv_step (
   input  jsv_pkg::scan_state_type state_cur,
   input  logic [7:0]              in_byte,
   input  logic                    start_string,
   input  logic                    text_end,
   output jsv_pkg::scan_state_type state_nxt,
   output jsv_pkg::verdict_type    verdict
);

   logic [7:0]       b;
   logic             hex_ok;
   logic [3:0]       hex_val;
   logic [15:0]      ev_next;
   logic [2:0]       hl_next;
   logic [1:0]       cl_next;
   logic [7:0]       cont_lo;
   logic [7:0]       cont_hi;
   jsv_pkg::len_type len_inc;
   logic             do_count;
   logic             do_fail;
   jsv_pkg::err_type fail_kind;
   logic             active;

   assign b = in_byte;

   // Decode a hex digit
   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (b >= jsv_pkg::BYTE_DIGIT_0 && b <= jsv_pkg::BYTE_DIGIT_9) begin
         hex_val = 4'(b - jsv_pkg::BYTE_DIGIT_0);
      end else if (b >= jsv_pkg::BYTE_UPPER_A && b <= jsv_pkg::BYTE_UPPER_F) begin
         hex_val = 4'(b - jsv_pkg::BYTE_UPPER_A + 8'd10);
      end else if (b >= jsv_pkg::BYTE_LOWER_A && b <= jsv_pkg::BYTE_LOWER_F) begin
         hex_val = 4'(b - jsv_pkg::BYTE_LOWER_A + 8'd10);
      end else begin
         hex_ok = 1'b0;
      end
   end

   // Shift in the digit and step the counters
   assign ev_next = {state_cur.escape_value[11:0], hex_val};
   assign hl_next = (state_cur.hex_left != 3'd0) ? state_cur.hex_left - 3'd1 : 3'd0;
   assign cl_next = (state_cur.cont_left != 2'd0) ? state_cur.cont_left - 2'd1 : 2'd0;

   // Saturating length increment
   assign len_inc = (&state_cur.length) ? state_cur.length
                                        : state_cur.length + jsv_pkg::len_type'(1);

   // Bounds on the next continuation byte
   always_comb begin
      cont_lo = jsv_pkg::UTF8_CONT_LO;
      cont_hi = jsv_pkg::UTF8_CONT_HI;
      unique case (state_cur.cont_range)
         jsv_pkg::RANGE_RAISED_LO: begin
            cont_lo = (state_cur.cont_left == 2'd3) ? jsv_pkg::UTF8_LO_AFTER_F0
                                                    : jsv_pkg::UTF8_LO_AFTER_E0;
         end
         jsv_pkg::RANGE_LOWERED_HI: begin
            cont_hi = (state_cur.cont_left == 2'd3) ? jsv_pkg::UTF8_HI_AFTER_F4
                                                    : jsv_pkg::UTF8_HI_AFTER_ED;
         end
         default: begin
         end
      endcase
   end

   assign active = (state_cur.mode == jsv_pkg::MODE_BODY) ||
                   (state_cur.mode == jsv_pkg::MODE_ESC)  ||
                   (state_cur.mode == jsv_pkg::MODE_HEX)  ||
                   (state_cur.mode == jsv_pkg::MODE_UTF8);

   // Advance the scan by one byte
   always_comb begin
      state_nxt      = state_cur;
      verdict.status = jsv_pkg::STATUS_SCAN;
      verdict.kind   = jsv_pkg::ERR_NONE;
      do_count       = 1'b0;
      do_fail        = 1'b0;
      fail_kind      = jsv_pkg::ERR_NONE;

      priority if (start_string) begin
         state_nxt      = jsv_pkg::RESET_STATE;
         state_nxt.mode = jsv_pkg::MODE_BODY;
      end else if (!active) begin
         state_nxt.mode = jsv_pkg::MODE_IDLE;
         verdict.status = jsv_pkg::STATUS_IDLE;
      end else if (text_end) begin
         do_fail = 1'b1;
         priority if (state_cur.mode == jsv_pkg::MODE_HEX) begin
            fail_kind = jsv_pkg::ERR_HEX;
         end else if (state_cur.mode == jsv_pkg::MODE_UTF8) begin
            fail_kind = jsv_pkg::ERR_UTF8;
         end else if (state_cur.surr_pending) begin
            fail_kind = jsv_pkg::ERR_SURROGATE;
         end else begin
            fail_kind = jsv_pkg::ERR_UNTERMINATED;
         end
      end else begin
         unique case (state_cur.mode)
            jsv_pkg::MODE_BODY: begin
               priority if (state_cur.surr_pending && b != jsv_pkg::BYTE_BSLASH) begin
                  do_fail   = 1'b1;
                  fail_kind = jsv_pkg::ERR_SURROGATE;
               end else if (b == jsv_pkg::BYTE_QUOTE) begin
                  state_nxt.mode = jsv_pkg::MODE_IDLE;
                  verdict.status = jsv_pkg::STATUS_CLOSED;
               end else if (b < jsv_pkg::BYTE_SPACE) begin
                  do_fail   = 1'b1;
                  fail_kind = jsv_pkg::ERR_CONTROL;
               end else if (b == jsv_pkg::BYTE_BSLASH) begin
                  state_nxt.escape_flag = 1'b1;
                  state_nxt.mode        = jsv_pkg::MODE_ESC;
                  do_count              = 1'b1;
               end else if (b >= jsv_pkg::UTF8_ASCII_TOP) begin
                  // classify the lead byte
                  state_nxt.mode       = jsv_pkg::MODE_UTF8;
                  state_nxt.cont_range = jsv_pkg::RANGE_FULL;
                  do_count             = 1'b1;
                  priority if (b >= jsv_pkg::UTF8_LEAD2_LO && b <= jsv_pkg::UTF8_LEAD2_HI) begin
                     state_nxt.cont_left = 2'd1;
                  end else if (b == jsv_pkg::UTF8_LEAD_E0) begin
                     state_nxt.cont_left  = 2'd2;
                     state_nxt.cont_range = jsv_pkg::RANGE_RAISED_LO;
                  end else if (b == jsv_pkg::UTF8_LEAD_ED) begin
                     state_nxt.cont_left  = 2'd2;
                     state_nxt.cont_range = jsv_pkg::RANGE_LOWERED_HI;
                  end else if (b > jsv_pkg::UTF8_LEAD_E0 && b <= jsv_pkg::UTF8_LEAD3_HI) begin
                     state_nxt.cont_left = 2'd2;
                  end else if (b == jsv_pkg::UTF8_LEAD_F0) begin
                     state_nxt.cont_left  = 2'd3;
                     state_nxt.cont_range = jsv_pkg::RANGE_RAISED_LO;
                  end else if (b > jsv_pkg::UTF8_LEAD_F0 && b <= jsv_pkg::UTF8_LEAD4_HI) begin
                     state_nxt.cont_left = 2'd3;
                  end else if (b == jsv_pkg::UTF8_LEAD_F4) begin
                     state_nxt.cont_left  = 2'd3;
                     state_nxt.cont_range = jsv_pkg::RANGE_LOWERED_HI;
                  end else begin
                     state_nxt = state_cur;
                     do_count  = 1'b0;
                     do_fail   = 1'b1;
                     fail_kind = jsv_pkg::ERR_UTF8;
                  end
               end else begin
                  do_count = 1'b1;
               end
            end

            jsv_pkg::MODE_ESC: begin
               priority if (state_cur.surr_pending && b != jsv_pkg::BYTE_LOWER_U) begin
                  do_fail   = 1'b1;
                  fail_kind = jsv_pkg::ERR_SURROGATE;
               end else if (b == jsv_pkg::BYTE_LOWER_U) begin
                  state_nxt.hex_left     = jsv_pkg::HEX_DIGITS;
                  state_nxt.escape_value = 16'd0;
                  state_nxt.mode         = jsv_pkg::MODE_HEX;
                  do_count               = 1'b1;
               end else if (b == jsv_pkg::BYTE_QUOTE   || b == jsv_pkg::BYTE_BSLASH  ||
                            b == jsv_pkg::BYTE_SLASH   || b == jsv_pkg::BYTE_LOWER_B ||
                            b == jsv_pkg::BYTE_LOWER_F || b == jsv_pkg::BYTE_LOWER_N ||
                            b == jsv_pkg::BYTE_LOWER_R || b == jsv_pkg::BYTE_LOWER_T) begin
                  state_nxt.mode = jsv_pkg::MODE_BODY;
                  do_count       = 1'b1;
               end else begin
                  do_fail   = 1'b1;
                  fail_kind = jsv_pkg::ERR_ESCAPE;
               end
            end

            jsv_pkg::MODE_HEX: begin
               if (!hex_ok) begin
                  do_fail   = 1'b1;
                  fail_kind = jsv_pkg::ERR_HEX;
               end else begin
                  state_nxt.escape_value = ev_next;
                  state_nxt.hex_left     = hl_next;
                  do_count               = 1'b1;
                  if (hl_next == 3'd0) begin
                     // pair up surrogate halves on the last digit
                     state_nxt.mode = jsv_pkg::MODE_BODY;
                     priority if (ev_next >= jsv_pkg::SURR_HIGH_LO &&
                                  ev_next < jsv_pkg::SURR_LOW_LO) begin
                        if (state_cur.surr_pending) begin
                           do_fail   = 1'b1;
                           fail_kind = jsv_pkg::ERR_SURROGATE;
                        end else begin
                           state_nxt.surr_pending = 1'b1;
                        end
                     end else if (ev_next >= jsv_pkg::SURR_LOW_LO &&
                                  ev_next <= jsv_pkg::SURR_LOW_HI) begin
                        if (!state_cur.surr_pending) begin
                           do_fail   = 1'b1;
                           fail_kind = jsv_pkg::ERR_SURROGATE;
                        end else begin
                           state_nxt.surr_pending = 1'b0;
                        end
                     end else if (state_cur.surr_pending) begin
                        do_fail   = 1'b1;
                        fail_kind = jsv_pkg::ERR_SURROGATE;
                     end else begin
                     end
                  end
               end
            end

            jsv_pkg::MODE_UTF8: begin
               if (b < cont_lo || b > cont_hi) begin
                  do_fail   = 1'b1;
                  fail_kind = jsv_pkg::ERR_UTF8;
               end else begin
                  state_nxt.cont_range = jsv_pkg::RANGE_FULL;
                  state_nxt.cont_left  = cl_next;
                  if (cl_next == 2'd0) begin
                     state_nxt.mode = jsv_pkg::MODE_BODY;
                  end
                  do_count = 1'b1;
               end
            end

            default: begin
            end
         endcase
      end

      // Failure drops to idle and leaves the count alone
      if (do_fail) begin
         state_nxt.mode = jsv_pkg::MODE_IDLE;
         verdict.status = jsv_pkg::STATUS_ERROR;
         verdict.kind   = fail_kind;
      end else if (do_count) begin
         state_nxt.length = len_inc;
      end
   end

endmodule

>>> rtl/core/json_string_utf8_validator_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// json_string_utf8_validator_unit
// Checks a quoted JSON string one byte per word: control bytes, escapes,
// \u hex digits, surrogate pairing and UTF-8 well-formedness.
// ============================================================================
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+----------------------------------
//   req      | in        | req_valid/req_stall  | in_byte, start_string, text_end
//   rsp      | out       | rsp_valid/rsp_stall  | status, error_kind, escape_seen,
//            |           |                      | raw_length
//
// One byte per cycle sustained unless the result side stalls, since the scan
// state is updated by the combinational next-state step as a byte is taken.
// Each result is registered in the output register, or in the skid stage.
// Reset empties the output register and its skid stage and puts the scan idle.
// A stalled result side fills the skid stage; req_stall rises only once both
// hold a result, so one more byte is taken behind a waiting result.
//
module json_string_utf8_validator_unit (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_in_byte,
   input  logic                        req_start_string,
   input  logic                        req_text_end,

   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_status,
   output logic [2:0]                  rsp_error_kind,
   output logic                        rsp_escape_seen,
   output logic [15:0]                 rsp_raw_length
);

   jsv_pkg::scan_state_type state_ff;
   jsv_pkg::scan_state_type state_in;
   jsv_pkg::verdict_type    verdict;
   jsv_pkg::rsp_word_type   word_in;
   jsv_pkg::rsp_word_type   out_ff;
   jsv_pkg::rsp_word_type   skid_ff;
   logic                    out_valid_ff;
   logic                    skid_valid_ff;
   logic                    push;
   logic                    pop;

   jsv_step u_step (
      .state_cur    (state_ff),
      .in_byte      (req_in_byte),
      .start_string (req_start_string),
      .text_end     (req_text_end),
      .state_nxt    (state_in),
      .verdict      (verdict)
   );

   // Build the result word from the updated state
   assign word_in.status       = verdict.status;
   assign word_in.kind         = verdict.kind;
   assign word_in.escape_seen  = state_in.escape_flag;
   assign word_in.raw_length   = jsv_pkg::rsp_len_type'(state_in.length);

   assign req_stall = skid_valid_ff;
   assign push      = req_valid && !skid_valid_ff;
   assign pop       = out_valid_ff && !rsp_stall;

   // Hold scan state and output valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= jsv_pkg::RESET_STATE;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (push) begin
            state_ff <= state_in;
         end
         if (skid_valid_ff) begin
            if (pop) begin
               skid_valid_ff <= 1'b0;
            end
         end else if (push) begin
            if (out_valid_ff && !pop) begin
               skid_valid_ff <= 1'b1;
            end else begin
               out_valid_ff <= 1'b1;
            end
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Move result words through output and skid registers
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (out_valid_ff && !pop) begin
            skid_ff <= word_in;
         end else begin
            out_ff <= word_in;
         end
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_ff.status;
   assign rsp_error_kind  = out_ff.kind;
   assign rsp_escape_seen = out_ff.escape_seen;
   assign rsp_raw_length  = out_ff.raw_length;

endmodule

>>> rtl/core/jsv_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// jsv_checker
// Port-level checks on the JSON string validator, bound to its top level.
// ============================================================================
module jsv_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [2:0]  rsp_error_kind,
   input logic [15:0] rsp_raw_length
);

   // Leave reset with empty output and an open input
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("output not empty after reset");

   // Error kind only with an error status
   a_kind_only_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != jsv_pkg::STATUS_ERROR) |->
         (rsp_error_kind == jsv_pkg::ERR_NONE))
      else $error("error kind without error status");

   // Error status always names a kind
   a_error_has_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == jsv_pkg::STATUS_ERROR) |->
         (rsp_error_kind != jsv_pkg::ERR_NONE))
      else $error("error status without kind");

   // Hold a stalled result
   a_stalled_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_raw_length) &&
                                    $stable(rsp_status)))
      else $error("stalled result changed");

endmodule

bind json_string_utf8_validator_unit jsv_checker u_jsv_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_status     (rsp_status),
   .rsp_error_kind (rsp_error_kind),
   .rsp_raw_length (rsp_raw_length)
);

>>> test/json_scan_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// json_scan_checker
// Watches both channels of the JSON string validator, predicts the result
// word of every byte taken, and compares each result word field by field
// against the oldest prediction.
// ============================================================================
module json_scan_checker
   import jsv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_start_string,
   input  logic        req_text_end,

   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_status,
   input  logic [2:0]  rsp_error_kind,
   input  logic        rsp_escape_seen,
   input  logic [15:0] rsp_raw_length,

   output int          failures,
   output int          pending,
   output int          results_checked,
   output int          error_results
);

   // Predicted scan state
   mode_type     mode         = MODE_IDLE;
   logic [2:0]   hex_left     = '0;
   logic [15:0]  esc_value    = '0;
   logic [1:0]   cont_left    = '0;
   range_type    cont_range   = RANGE_FULL;
   logic         surr_pending = 1'b0;
   logic         escape_flag  = 1'b0;
   len_type      length       = '0;

   rsp_word_type expected_words[$];
   int           mismatch_count = 0;
   int           checked_count  = 0;
   int           error_count    = 0;
   int           waiting        = 0;

   assign failures        = mismatch_count;
   assign pending         = waiting;
   assign results_checked = checked_count;
   assign error_results   = error_count;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("mismatch at result %0d: %s got %0h expected %0h",
               checked_count, what, got, want);
   endtask

   // Advance the predicted scan by one byte and return its result word
   function automatic rsp_word_type predict_scan(input logic [7:0] b, input logic opening,
                                                 input logic ending);
      status_type st;
      err_type    kind;
      logic       take;
      logic       is_hex;
      logic [3:0] digit;
      logic [7:0] lo;
      logic [7:0] hi;
      st   = STATUS_SCAN;
      kind = ERR_NONE;
      take = 1'b0;
      if (opening) begin
         mode         = MODE_BODY;
         hex_left     = '0;
         esc_value    = '0;
         cont_left    = '0;
         cont_range   = RANGE_FULL;
         surr_pending = 1'b0;
         escape_flag  = 1'b0;
         length       = '0;
      end else if (mode == MODE_IDLE) begin
         st = STATUS_IDLE;
      end else if (ending) begin
         if (mode == MODE_HEX) kind = ERR_HEX;
         else if (mode == MODE_UTF8) kind = ERR_UTF8;
         else if (surr_pending) kind = ERR_SURROGATE;
         else kind = ERR_UNTERMINATED;
      end else begin
         case (mode)
            MODE_BODY: begin
               if (surr_pending && b != BYTE_BSLASH) begin
                  kind = ERR_SURROGATE;
               end else if (b == BYTE_QUOTE) begin
                  st   = STATUS_CLOSED;
                  mode = MODE_IDLE;
               end else if (b < BYTE_SPACE) begin
                  kind = ERR_CONTROL;
               end else if (b == BYTE_BSLASH) begin
                  escape_flag = 1'b1;
                  mode        = MODE_ESC;
                  take        = 1'b1;
               end else if (b < UTF8_ASCII_TOP) begin
                  take = 1'b1;
               end else begin
                  // classify the lead byte and set up the continuation bounds
                  take       = 1'b1;
                  mode       = MODE_UTF8;
                  cont_range = RANGE_FULL;
                  if (b >= UTF8_LEAD2_LO && b <= UTF8_LEAD2_HI) begin
                     cont_left = 2'd1;
                  end else if (b >= UTF8_LEAD_E0 && b <= UTF8_LEAD3_HI) begin
                     cont_left = 2'd2;
                     if (b == UTF8_LEAD_E0) cont_range = RANGE_RAISED_LO;
                     else if (b == UTF8_LEAD_ED) cont_range = RANGE_LOWERED_HI;
                  end else if (b >= UTF8_LEAD_F0 && b <= UTF8_LEAD_F4) begin
                     cont_left = 2'd3;
                     if (b == UTF8_LEAD_F0) cont_range = RANGE_RAISED_LO;
                     else if (b == UTF8_LEAD_F4) cont_range = RANGE_LOWERED_HI;
                  end else begin
                     kind = ERR_UTF8;
                  end
               end
            end
            MODE_ESC: begin
               if (surr_pending && b != BYTE_LOWER_U) begin
                  kind = ERR_SURROGATE;
               end else if (b == BYTE_LOWER_U) begin
                  hex_left  = HEX_DIGITS;
                  esc_value = '0;
                  mode      = MODE_HEX;
                  take      = 1'b1;
               end else if (b == BYTE_QUOTE || b == BYTE_BSLASH || b == BYTE_SLASH ||
                            b == BYTE_LOWER_B || b == BYTE_LOWER_F || b == BYTE_LOWER_N ||
                            b == BYTE_LOWER_R || b == BYTE_LOWER_T) begin
                  mode = MODE_BODY;
                  take = 1'b1;
               end else begin
                  kind = ERR_ESCAPE;
               end
            end
            MODE_HEX: begin
               is_hex = 1'b1;
               digit  = '0;
               if (b >= BYTE_DIGIT_0 && b <= BYTE_DIGIT_9) digit = 4'(b - BYTE_DIGIT_0);
               else if (b >= BYTE_UPPER_A && b <= BYTE_UPPER_F)
                  digit = 4'(b - BYTE_UPPER_A + 8'd10);
               else if (b >= BYTE_LOWER_A && b <= BYTE_LOWER_F)
                  digit = 4'(b - BYTE_LOWER_A + 8'd10);
               else is_hex = 1'b0;
               if (!is_hex) begin
                  kind = ERR_HEX;
               end else begin
                  take      = 1'b1;
                  esc_value = {esc_value[11:0], digit};
                  if (hex_left != 0) hex_left--;
                  // last digit: pair up surrogate halves
                  if (hex_left == 0) begin
                     mode = MODE_BODY;
                     if (esc_value >= SURR_HIGH_LO && esc_value < SURR_LOW_LO) begin
                        if (surr_pending) kind = ERR_SURROGATE;
                        else surr_pending = 1'b1;
                     end else if (esc_value >= SURR_LOW_LO && esc_value <= SURR_LOW_HI) begin
                        if (!surr_pending) kind = ERR_SURROGATE;
                        else surr_pending = 1'b0;
                     end else if (surr_pending) begin
                        kind = ERR_SURROGATE;
                     end
                  end
               end
            end
            MODE_UTF8: begin
               lo = UTF8_CONT_LO;
               hi = UTF8_CONT_HI;
               if (cont_range == RANGE_RAISED_LO)
                  lo = (cont_left == 2'd3) ? UTF8_LO_AFTER_F0 : UTF8_LO_AFTER_E0;
               else if (cont_range == RANGE_LOWERED_HI)
                  hi = (cont_left == 2'd3) ? UTF8_HI_AFTER_F4 : UTF8_HI_AFTER_ED;
               if (b < lo || b > hi) begin
                  kind = ERR_UTF8;
               end else begin
                  take       = 1'b1;
                  cont_range = RANGE_FULL;
                  if (cont_left != 0) cont_left--;
                  if (cont_left == 0) mode = MODE_BODY;
               end
            end
            default: begin
               st   = STATUS_IDLE;
               mode = MODE_IDLE;
            end
         endcase
      end
      // errors go idle and leave the count alone; the count saturates
      if (kind != ERR_NONE) begin
         st   = STATUS_ERROR;
         mode = MODE_IDLE;
      end else if (take && length != '1) begin
         length = length + 1'b1;
      end
      return '{status: st, kind: kind, escape_seen: escape_flag,
               raw_length: rsp_len_type'(length)};
   endfunction

   // Check each result word taken, predict on each byte taken
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         mode         = MODE_IDLE;
         hex_left     = '0;
         esc_value    = '0;
         cont_left    = '0;
         cont_range   = RANGE_FULL;
         surr_pending = 1'b0;
         escape_flag  = 1'b0;
         length       = '0;
         expected_words.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               report_mismatch("result word with none expected", rsp_status, '0);
            end else begin
               want = expected_words.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_error_kind !== want.kind)
                  report_mismatch("error_kind", rsp_error_kind, want.kind);
               if (rsp_escape_seen !== want.escape_seen)
                  report_mismatch("escape_seen", rsp_escape_seen, want.escape_seen);
               if (rsp_raw_length !== want.raw_length)
                  report_mismatch("raw_length", rsp_raw_length, want.raw_length);
               if (want.status == STATUS_ERROR) error_count++;
               checked_count++;
            end
         end
         if (req_valid && !req_stall) begin
            expected_words.push_back(predict_scan(req_in_byte, req_start_string,
                                                  req_text_end));
         end
      end
      waiting <= expected_words.size();
   end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Drives JSON string bytes into the validator: a short directed opening,
// then mostly well-formed strings with random content, escapes, surrogate
// pairs and UTF-8, mixed with faults. Both sides idle in random bursts,
// except in the last part of the run.
// ============================================================================
module testbench;
   import jsv_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_WORDS = 440;
   localparam int TOTAL_WORDS = 500;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte      = '0;
   logic        req_start_string = 1'b0;
   logic        req_text_end     = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [1:0]  rsp_status;
   logic [2:0]  rsp_error_kind;
   logic        rsp_escape_seen;
   logic [15:0] rsp_raw_length;

   int failures;
   int pending;
   int results_checked;
   int error_results;

   int cycle_count = 0;
   int words_sent  = 0;
   int gap_pct     = 20;
   int stall_pct   = 0;
   int stall_left  = 0;
   int pct_timer   = 0;
   bit calm        = 1'b0;

   always #6 clock = ~clock;

   json_string_utf8_validator_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_start_string (req_start_string),
      .req_text_end     (req_text_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_error_kind   (rsp_error_kind),
      .rsp_escape_seen  (rsp_escape_seen),
      .rsp_raw_length   (rsp_raw_length)
   );

   json_scan_checker scan_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_start_string (req_start_string),
      .req_text_end     (req_text_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_error_kind   (rsp_error_kind),
      .rsp_escape_seen  (rsp_escape_seen),
      .rsp_raw_length   (rsp_raw_length),
      .failures         (failures),
      .pending          (pending),
      .results_checked  (results_checked),
      .error_results    (error_results)
   );

   // Stall the result side in bursts; the burst rate is redrawn when pct_timer runs out
   always @(posedge clock) begin
      if (pct_timer == 0) begin
         pct_timer <= 64;
         case ($urandom_range(0, 2))
            0: stall_pct <= 0;
            1: stall_pct <= 10;
            default: stall_pct <= 35;
         endcase
      end else begin
         pct_timer <= pct_timer - 1;
      end
      if (reset || calm) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 14);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("testbench: errors");
         $finish;
      end
   end

   // Drive one word and hold it until taken, after an optional idle burst
   task automatic send_word(input logic [7:0] b, input logic opening, input logic ending);
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_valid        <= 1'b0;
         req_in_byte      <= 8'($urandom);
         req_start_string <= 1'($urandom);
         req_text_end     <= 1'($urandom);
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_in_byte      <= b;
      req_start_string <= opening;
      req_text_end     <= ending;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return BYTE_DIGIT_0 + 8'(n);
      if ($urandom_range(0, 1) == 1) return BYTE_UPPER_A + 8'(n - 4'd10);
      return BYTE_LOWER_A + 8'(n - 4'd10);
   endfunction

   // Backslash-u followed by the leading digits of a value
   task automatic send_unicode_escape(input logic [15:0] v, input int digits);
      send_word(BYTE_BSLASH, 1'b0, 1'b0);
      send_word(BYTE_LOWER_U, 1'b0, 1'b0);
      for (int i = 0; i < digits; i++) begin
         send_word(hex_char(v[15-4*i -: 4]), 1'b0, 1'b0);
      end
   endtask

   // One UTF-8 sequence; at position bad_at drop a bad byte or, if truncate, stop
   task automatic send_utf8(input int bad_at, input bit truncate);
      logic [7:0] lead;
      logic [7:0] c;
      logic [7:0] lo;
      logic [7:0] hi;
      int         n;
      lead = 8'($urandom_range(UTF8_LEAD2_LO, UTF8_LEAD_F4));
      n    = (lead <= UTF8_LEAD2_HI) ? 1 : (lead <= UTF8_LEAD3_HI) ? 2 : 3;
      if (bad_at >= n) bad_at = n - 1;
      send_word(lead, 1'b0, 1'b0);
      for (int i = 0; i < n; i++) begin
         lo = UTF8_CONT_LO;
         hi = UTF8_CONT_HI;
         if (i == 0) begin
            if (lead == UTF8_LEAD_E0) lo = UTF8_LO_AFTER_E0;
            else if (lead == UTF8_LEAD_F0) lo = UTF8_LO_AFTER_F0;
            else if (lead == UTF8_LEAD_ED) hi = UTF8_HI_AFTER_ED;
            else if (lead == UTF8_LEAD_F4) hi = UTF8_HI_AFTER_F4;
         end
         if (i == bad_at) begin
            if (truncate) return;
            if ($urandom_range(0, 1) == 1 && lo > UTF8_CONT_LO)
               c = 8'($urandom_range(UTF8_CONT_LO, lo - 8'd1));
            else if ($urandom_range(0, 1) == 1 && hi < UTF8_CONT_HI)
               c = 8'($urandom_range(hi + 8'd1, UTF8_CONT_HI));
            else
               do c = 8'($urandom); while (c >= lo && c <= hi);
            send_word(c, 1'b0, 1'b0);
            return;
         end
         case ($urandom_range(0, 3))
            0: c = lo;
            1: c = hi;
            default: c = 8'($urandom_range(lo, hi));
         endcase
         send_word(c, 1'b0, 1'b0);
      end
   endtask

   // One well-formed piece of string content
   task automatic send_token();
      logic [7:0]  c;
      logic [15:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            do c = 8'($urandom_range(BYTE_SPACE, 8'h7F));
            while (c == BYTE_QUOTE || c == BYTE_BSLASH);
            send_word(c, 1'b0, 1'b0);
         end
         4: begin
            send_word(BYTE_BSLASH, 1'b0, 1'b0);
            case ($urandom_range(0, 7))
               0: c = BYTE_QUOTE;
               1: c = BYTE_BSLASH;
               2: c = BYTE_SLASH;
               3: c = BYTE_LOWER_B;
               4: c = BYTE_LOWER_F;
               5: c = BYTE_LOWER_N;
               6: c = BYTE_LOWER_R;
               default: c = BYTE_LOWER_T;
            endcase
            send_word(c, 1'b0, 1'b0);
         end
         5: begin
            case ($urandom_range(0, 7))
               0: v = 16'h0000;
               1: v = SURR_HIGH_LO - 16'd1;
               2: v = SURR_LOW_HI + 16'd1;
               3: v = 16'hFFFF;
               default: do v = 16'($urandom); while (v >= SURR_HIGH_LO && v <= SURR_LOW_HI);
            endcase
            send_unicode_escape(v, 4);
         end
         6: begin
            send_unicode_escape(16'($urandom_range(SURR_HIGH_LO, SURR_LOW_LO - 16'd1)), 4);
            send_unicode_escape(16'($urandom_range(SURR_LOW_LO, SURR_LOW_HI)), 4);
         end
         default: send_utf8(-1, 1'b0);
      endcase
   endtask

   // One broken piece of content that ends the string in an error, or one random byte
   task automatic send_fault();
      logic [7:0]  c;
      logic [15:0] v;
      case ($urandom_range(0, 8))
         0: send_word(8'($urandom_range(0, BYTE_SPACE - 8'd1)), 1'b0, 1'b0);
         1: begin
            send_word(BYTE_BSLASH, 1'b0, 1'b0);
            do c = 8'($urandom);
            while (c == BYTE_QUOTE || c == BYTE_BSLASH || c == BYTE_SLASH ||
                   c == BYTE_LOWER_B || c == BYTE_LOWER_F || c == BYTE_LOWER_N ||
                   c == BYTE_LOWER_R || c == BYTE_LOWER_T || c == BYTE_LOWER_U);
            send_word(c, 1'b0, 1'b0);
         end
         2: begin
            send_unicode_escape(16'($urandom), $urandom_range(0, 3));
            do c = 8'($urandom);
            while ((c >= BYTE_DIGIT_0 && c <= BYTE_DIGIT_9) ||
                   (c >= BYTE_UPPER_A && c <= BYTE_UPPER_F) ||
                   (c >= BYTE_LOWER_A && c <= BYTE_LOWER_F));
            send_word(c, 1'b0, 1'b0);
         end
         3: send_unicode_escape(16'($urandom_range(SURR_LOW_LO, SURR_LOW_HI)), 4);
         4: begin
            // high half followed by anything but its low half
            send_unicode_escape(16'($urandom_range(SURR_HIGH_LO, SURR_LOW_LO - 16'd1)), 4);
            case ($urandom_range(0, 3))
               0: begin
                  do c = 8'($urandom); while (c == BYTE_BSLASH);
                  send_word(c, 1'b0, 1'b0);
               end
               1: begin
                  send_word(BYTE_BSLASH, 1'b0, 1'b0);
                  do c = 8'($urandom); while (c == BYTE_LOWER_U);
                  send_word(c, 1'b0, 1'b0);
               end
               2: begin
                  do v = 16'($urandom); while (v >= SURR_LOW_LO && v <= SURR_LOW_HI);
                  send_unicode_escape(v, 4);
               end
               default: send_word(8'($urandom), 1'b0, 1'b1);
            endcase
         end
         5: begin
            if ($urandom_range(0, 1) == 1)
               c = 8'($urandom_range(UTF8_CONT_LO, UTF8_LEAD2_LO - 8'd1));
            else
               c = 8'($urandom_range(UTF8_LEAD_F4 + 8'd1, 8'hFF));
            send_word(c, 1'b0, 1'b0);
         end
         6: send_utf8($urandom_range(0, 2), 1'b0);
         7: begin
            // text ends in the middle of something
            case ($urandom_range(0, 2))
               0: send_unicode_escape(16'($urandom), $urandom_range(0, 3));
               1: send_utf8($urandom_range(0, 2), 1'b1);
               default: send_word(BYTE_BSLASH, 1'b0, 1'b0);
            endcase
            send_word(8'($urandom), 1'b0, 1'b1);
         end
         default: send_word(8'($urandom), 1'b0, 1'b0);
      endcase
   endtask

   task automatic send_random_string();
      case ($urandom_range(0, 3))
         0: gap_pct = 0;
         1: gap_pct = 10;
         default: gap_pct = 30;
      endcase
      send_word(8'($urandom), 1'b1, 1'($urandom));
      repeat ($urandom_range(0, 10)) send_token();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: send_word(BYTE_QUOTE, 1'b0, 1'b0);
         5: send_word(8'($urandom), 1'b0, 1'b1);
         6, 7, 8: send_fault();
         default: return;
      endcase
      // bytes that arrive while idle
      repeat ($urandom_range(0, 2)) send_word(8'($urandom), 1'b0, 1'($urandom));
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // opening quote and text end together: the opening wins
      send_word(BYTE_QUOTE, 1'b1, 1'b1);
      send_word(8'hFF, 1'b0, 1'b0);
      send_word(8'h00, 1'b0, 1'b0);
      send_word(8'h00, 1'b0, 1'b1);
      // high surrogate half not followed by a backslash
      send_word(BYTE_QUOTE, 1'b1, 1'b0);
      send_unicode_escape(SURR_HIGH_LO, 4);
      send_word(8'h78, 1'b0, 1'b0);
      // largest code point, then text end inside the sequence
      send_word(BYTE_QUOTE, 1'b1, 1'b0);
      send_word(UTF8_LEAD_F4, 1'b0, 1'b0);
      send_word(UTF8_HI_AFTER_F4, 1'b0, 1'b0);
      send_word(UTF8_CONT_HI, 1'b0, 1'b0);
      send_word(8'h00, 1'b0, 1'b1);
      // control byte
      send_word(BYTE_QUOTE, 1'b1, 1'b0);
      send_word(BYTE_SPACE - 8'd1, 1'b0, 1'b0);
      // text end inside hex digits
      send_word(BYTE_QUOTE, 1'b1, 1'b0);
      send_unicode_escape(SURR_LOW_LO, 2);
      send_word(8'h00, 1'b0, 1'b1);
      // plain string closed
      send_word(BYTE_QUOTE, 1'b1, 1'b0);
      send_word(8'h7F, 1'b0, 1'b0);
      send_word(BYTE_QUOTE, 1'b0, 1'b0);

      while (words_sent < RANDOM_WORDS) send_random_string();

      // no idling from here on
      calm = 1'b1;
      while (words_sent < TOTAL_WORDS) send_random_string();
      req_valid <= 1'b0;

      // drain, then keep watching for anything unexpected
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("summary: %0d words driven, %0d result words checked, %0d error verdicts",
               words_sent, results_checked, error_results);
      $display("summary: directed corner strings, then random strings with escapes, %s",
               "surrogate pairs, UTF-8 and faults under random idling and stalls");
      if (failures == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/jsv_pkg.sv
rtl/core/jsv_step.sv
rtl/core/json_string_utf8_validator_unit.sv
rtl/core/jsv_checker.sv
test/json_scan_checker.sv
test/testbench.sv
